FILE: hdl/vrds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrds_pkg: shared types and constants for the voxel ray stepper
// Result codes, controller commands and the status returned by the datapath.
// ----------------------------------------------------------------------------
package vrds_pkg;

  localparam int unsigned ChunkSize = 16;
  localparam int unsigned ChunkBits = $clog2(ChunkSize);
  localparam logic [23:0] MaxDistReset = 24'd327680;
  localparam logic [31:0] SatMax = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;

  typedef struct packed {
    logic load;      // latch origin/direction, clear travelled distance
    logic div_go;    // start divider for current axis
    logic div_save;  // store reciprocal and first crossing for axis
    logic step;      // take one DDA step
  } vrds_cmd_t;

  typedef struct packed {
    logic div_done;
    logic [1:0] axis;   // axis in reciprocal phase
    logic below_limit;  // travelled < range limit
  } vrds_sts_t;

endpackage

FILE: hdl/vrds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrds_ctrl: ray controller
// Sequences ray setup, stepping and result generation.
// ----------------------------------------------------------------------------
module vrds_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_action_i,
  input  logic                 in_solid_i,
  output logic                 in_ready_o,
  input  logic                 out_free_i,
  output logic                 emit_o,
  output logic [1:0]           emit_kind_o,
  output logic                 emit_hitsel_o,
  output vrds_pkg::vrds_cmd_t  cmd_o,
  input  vrds_pkg::vrds_sts_t  sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_LIM  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic active_q, active_d;
  logic acc;

  assign in_ready_o = (state_q == S_IDLE) && out_free_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    active_d = active_q;
    cmd_o = '0;
    emit_o = 1'b0;
    emit_kind_o = vrds_pkg::KIND_MISS;
    emit_hitsel_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (!in_action_i) begin
            cmd_o.load = 1'b1;
            active_d = 1'b0;
            state_d = S_DIV;
          end else if (!active_q) begin
            emit_o = 1'b1;
          end else if (in_solid_i) begin
            emit_o = 1'b1;
            emit_kind_o = vrds_pkg::KIND_HIT;
            emit_hitsel_o = 1'b1;
            active_d = 1'b0;
          end else if (sts_i.below_limit) begin
            cmd_o.step = 1'b1;
            state_d = S_FIN;
          end else begin
            emit_o = 1'b1;
            active_d = 1'b0;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_go = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_save = 1'b1;
          if (sts_i.axis == 2'd2) begin
            state_d = S_LIM;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      // all crossings stored; first step or immediate miss
      S_LIM: begin
        if (sts_i.below_limit) begin
          cmd_o.step = 1'b1;
          state_d = S_FIN;
        end else begin
          emit_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        emit_o = 1'b1;
        emit_kind_o = vrds_pkg::KIND_QUERY;
        active_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      active_q <= 1'b0;
    end else begin
      state_q <= state_d;
      active_q <= active_d;
    end
  end

endmodule

FILE: hdl/vrds_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrds_dp: ray datapath
// Serial reciprocal divider, crossing registers, step selection and voxel state.
// ----------------------------------------------------------------------------
module vrds_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [23:0]          max_dist_i,
  input  logic [95:0]          origin_i,
  input  logic [47:0]          dir_i,
  input  vrds_pkg::vrds_cmd_t  cmd_i,
  output vrds_pkg::vrds_sts_t  sts_o,
  output logic [47:0]          cell_o,
  output logic [2:0]           neg_o,
  output logic [1:0]           axis_o
);

  logic [15:0] cell_q [3];
  logic [31:0] cross_q [3];
  logic [31:0] unit_q [3];
  logic [2:0]  neg_q;
  logic [31:0] trav_q;
  logic [1:0]  eaxis_q;
  logic [15:0] frac_q [3];
  logic [15:0] mag_q [3];
  logic [1:0]  dax_q;

  // restoring divider: 2^30 / mag, one quotient bit per cycle
  logic [31:0] quo_q;
  logic [15:0] rem_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic        din;
  logic [16:0] rsh;
  logic [17:0] rdiff;
  logic [15:0] dmag;

  assign dmag = mag_q[dax_q];
  // dividend is 2^30: only bit 30 is set
  assign din = (cnt_q == 5'd30);
  assign rsh = {rem_q, din};
  assign rdiff = {1'b0, rsh} - {2'b0, dmag};

  // first crossing: (span * unit) >> 16 from a shifted unit term and a 16x32 product, saturated
  logic [16:0] span;
  logic [31:0] recip;
  logic [48:0] prod;
  logic [31:0] first;
  assign recip = (dmag == '0) ? vrds_pkg::SatMax : quo_q;
  assign span = neg_q[dax_q] ? {1'b0, frac_q[dax_q]} : 17'h10000 - {1'b0, frac_q[dax_q]};
  assign prod = {17'b0, span[16] ? recip : 32'b0} << 16 |
                49'(span[15:0] * recip);
  assign first = (prod[48:16] > 33'(vrds_pkg::SatMax)) ? vrds_pkg::SatMax : prod[47:16];

  // step choice
  logic [1:0]  sax;
  logic [32:0] nsum;
  always_comb begin
    if (cross_q[0] < cross_q[1] && cross_q[0] < cross_q[2]) sax = 2'd0;
    else if (cross_q[1] < cross_q[2]) sax = 2'd1;
    else sax = 2'd2;
  end
  assign nsum = {1'b0, cross_q[sax]} + {1'b0, unit_q[sax]};

  assign sts_o.div_done = done_q;
  assign sts_o.axis = dax_q;
  assign sts_o.below_limit = trav_q < {8'b0, max_dist_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      dax_q <= '0;
      neg_q <= '0;
      trav_q <= '0;
      eaxis_q <= '0;
      for (int i = 0; i < 3; i++) begin
        cell_q[i] <= '0;
        cross_q[i] <= '0;
        unit_q[i] <= '0;
        frac_q[i] <= '0;
        mag_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (cmd_i.load) begin
        dax_q <= '0;
        trav_q <= '0;
        eaxis_q <= '0;
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= dir_i[16*i+15];
          mag_q[i] <= dir_i[16*i+15] ? 16'(-dir_i[16*i +: 16]) : dir_i[16*i +: 16];
          frac_q[i] <= origin_i[32*i +: 16];
          cell_q[i] <= origin_i[32*i+16 +: 16];
        end
      end
      if (cmd_i.div_go) begin
        busy_q <= 1'b1;
        cnt_q <= 5'd31;
        rem_q <= '0;
        quo_q <= '0;
      end else if (busy_q) begin
        if (!rdiff[17]) begin
          rem_q <= rdiff[15:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rsh[15:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
      if (cmd_i.div_save) begin
        unit_q[dax_q] <= recip;
        cross_q[dax_q] <= first;
        dax_q <= (dax_q == 2'd2) ? 2'd0 : dax_q + 2'd1;
      end
      if (cmd_i.step) begin
        cell_q[sax] <= neg_q[sax] ? cell_q[sax] - 16'd1 : cell_q[sax] + 16'd1;
        trav_q <= cross_q[sax];
        cross_q[sax] <= nsum[32] ? vrds_pkg::SatMax : nsum[31:0];
        eaxis_q <= sax;
      end
    end
  end

  assign cell_o = {cell_q[2], cell_q[1], cell_q[0]};
  assign neg_o = neg_q;
  assign axis_o = eaxis_q;

endmodule

FILE: hdl/voxel_ray_dda_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_dda_stepper: 3D grid traversal stepper
// Loads a ray, computes reciprocals and first crossings, then steps voxel by
// voxel on each answer until hit, miss or distance limit.
// ----------------------------------------------------------------------------
// channel | dir | contents
// s_axis  | in  | tuser=action, tdata=origin xyz, dir xyz, solid, kind
// m_axis  | out | tuser=result kind, tdata=voxel xyz, local xyz, normal xyz, hit_kind
// cfg     | in  | range limit write
//
// Start request: three serial divisions, a limit check and first step (or a miss),
// then the result; no request is accepted meanwhile. Answer request: hit or miss
// on acceptance, else a step (compare, saturating add) and then its result.
// Reset: no ray in flight, range limit = 5.0.
// Output register holds result; input stalls while it is full and not draining.
// ----------------------------------------------------------------------------
module voxel_ray_dda_stepper (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic         s_axis_tuser,   // action
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, voxel_solid, voxel_kind
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [1:0]   m_axis_tuser,   // result_kind
  // voxel_x/y/z, local_x/y/z, normal_x/y/z, hit_kind
  output logic [87:0]  m_axis_tdata
);

  logic [23:0] maxd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) maxd_q <= vrds_pkg::MaxDistReset;
    else if (cfg_we_i) maxd_q <= cfg_wdata_i;
  end

  vrds_pkg::vrds_cmd_t cmd;
  vrds_pkg::vrds_sts_t sts;
  logic emit, hitsel;
  logic [1:0] ekind;
  logic [47:0] vox_pos;
  logic [2:0] neg;
  logic [1:0] eaxis;
  logic out_free;
  logic [85:0] res_q;
  logic [1:0]  rkind_q;
  logic        rvalid_q;

  assign out_free = !rvalid_q || m_axis_tready;

  vrds_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_action_i(s_axis_tuser),
    .in_solid_i(s_axis_tdata[144]), .in_ready_o(s_axis_tready),
    .out_free_i(out_free), .emit_o(emit), .emit_kind_o(ekind),
    .emit_hitsel_o(hitsel), .cmd_o(cmd), .sts_i(sts)
  );

  vrds_dp u_dp (
    .clk_i, .rst_ni, .max_dist_i(maxd_q),
    .origin_i(s_axis_tdata[95:0]), .dir_i(s_axis_tdata[143:96]),
    .cmd_i(cmd), .sts_o(sts), .cell_o(vox_pos), .neg_o(neg), .axis_o(eaxis)
  );

  // assemble result; a miss carries zeros
  logic [85:0] res;
  always_comb begin
    res = '0;
    if (ekind != vrds_pkg::KIND_MISS) begin
      res[47:0] = vox_pos;
      for (int i = 0; i < 3; i++) begin
        // floored modulo of a power-of-two chunk: low bits of the voxel
        res[48+8*i +: 8] = 8'(vox_pos[16*i +: vrds_pkg::ChunkBits]);
        // normal is minus the step sign on the entered axis
        res[72+2*i +: 2] = (eaxis == 2'(i)) ? (neg[i] ? 2'b01 : 2'b11) : 2'b00;
      end
      // hit kind comes straight from the answer being accepted
      res[85:78] = hitsel ? s_axis_tdata[152:145] : 8'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      rkind_q <= '0;
      res_q <= '0;
    end else if (emit) begin
      rvalid_q <= 1'b1;
      rkind_q <= ekind;
      res_q <= res;
    end else if (m_axis_tready) begin
      rvalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = rvalid_q;
  assign m_axis_tuser = rkind_q;
  assign m_axis_tdata = {2'b00, res_q};

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result emitted into full output");
  a_no_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == vrds_pkg::KIND_MISS |-> m_axis_tdata == '0)
    else $error("miss carries data");
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !s_axis_tready) else $error("input taken during setup");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for voxel_ray_dda_stepper
// Drives start and answer requests with random gaps, stalls the result side
// at random, predicts every query/hit/miss in the bench and compares each
// result field by field. Limit register is swept through several values.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic        action;
    logic [31:0] org [3];
    logic [15:0] dir [3];
    logic        solid;
    logic [7:0]  kind;
  } ray_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] vox [3];
    logic [7:0]  loc [3];
    logic [1:0]  nrm [3];
    logic [7:0]  hit_kind;
  } ray_res_t;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [23:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic         s_axis_tuser = 0;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [1:0]   m_axis_tuser;
  logic [87:0]  m_axis_tdata;

  voxel_ray_dda_stepper uut (.*);

  initial forever #4 clk_i = ~clk_i;

  // Bench copy of the stepper state
  logic [23:0] lim_q;
  logic [15:0] pos_q [3];
  logic [31:0] cross_q [3];
  logic [31:0] unit_q [3];
  logic        neg_q [3];
  logic [31:0] trav_q;
  int          axis_q;
  logic        active_q;

  ray_res_t    pending_q [$];
  int          errors = 0;
  int          n_req = 0, n_hit = 0, n_miss = 0, n_query = 0;
  bit          calm = 0;     // no idling on either side while set
  int          quiet = 0;    // cycles with nothing accepted

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? vrds_pkg::SatMax : s[31:0];
  endfunction

  function automatic void advance_cell();
    int ax;
    if (cross_q[0] < cross_q[1] && cross_q[0] < cross_q[2]) ax = 0;
    else if (cross_q[1] < cross_q[2]) ax = 1;
    else ax = 2;
    pos_q[ax] = neg_q[ax] ? pos_q[ax] - 16'd1 : pos_q[ax] + 16'd1;
    trav_q = cross_q[ax];
    cross_q[ax] = sat_sum(cross_q[ax], unit_q[ax]);
    axis_q = ax;
  endfunction

  function automatic ray_res_t voxel_result(logic [1:0] kind, logic [7:0] hk);
    ray_res_t r;
    int v, m;
    r.kind = kind;
    r.hit_kind = hk;
    for (int i = 0; i < 3; i++) begin
      r.vox[i] = pos_q[i];
      v = int'($signed(pos_q[i]));
      m = v % int'(vrds_pkg::ChunkSize);
      if (m < 0) m += int'(vrds_pkg::ChunkSize);
      r.loc[i] = m[7:0];
      r.nrm[i] = (i == axis_q) ? (neg_q[i] ? 2'b01 : 2'b11) : 2'b00;
    end
    return r;
  endfunction

  function automatic ray_res_t miss_result();
    ray_res_t r;
    r.kind = vrds_pkg::KIND_MISS;
    r.hit_kind = 8'd0;
    for (int i = 0; i < 3; i++) begin
      r.vox[i] = '0;
      r.loc[i] = '0;
      r.nrm[i] = '0;
    end
    return r;
  endfunction

  // Expected result of one accepted request; updates the bench state.
  function automatic ray_res_t traverse_predict(ray_req_t q);
    logic [15:0] mag;
    logic [16:0] span;
    logic [63:0] prod;
    if (!q.action) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] = q.dir[i][15];
        mag = neg_q[i] ? 16'd0 - q.dir[i] : q.dir[i];
        unit_q[i] = (mag == 0) ? vrds_pkg::SatMax : 32'(64'd1073741824 / mag);
        pos_q[i] = q.org[i][31:16];
        span = neg_q[i] ? {1'b0, q.org[i][15:0]} : 17'h10000 - {1'b0, q.org[i][15:0]};
        prod = (64'(span) * 64'(unit_q[i])) >> 16;
        cross_q[i] = (prod > 64'(vrds_pkg::SatMax)) ? vrds_pkg::SatMax : prod[31:0];
      end
      trav_q = 0;
      axis_q = 0;
      if (trav_q < {8'd0, lim_q}) begin
        advance_cell();
        active_q = 1;
        return voxel_result(vrds_pkg::KIND_QUERY, 8'd0);
      end
      active_q = 0;
      return miss_result();
    end
    if (!active_q) return miss_result();
    if (q.solid) begin
      active_q = 0;
      return voxel_result(vrds_pkg::KIND_HIT, q.kind);
    end
    if (trav_q < {8'd0, lim_q}) begin
      advance_cell();
      return voxel_result(vrds_pkg::KIND_QUERY, 8'd0);
    end
    active_q = 0;
    return miss_result();
  endfunction

  // Send one request: random idle cycles, then hold until accepted.
  task automatic send_request(ray_req_t q);
    logic [152:0] packed_q;
    while (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    packed_q = {q.kind, q.solid, q.dir[2], q.dir[1], q.dir[0],
                q.org[2], q.org[1], q.org[0]};
    s_axis_tdata  <= {7'd0, packed_q};
    s_axis_tuser  <= q.action;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(traverse_predict(q));
    n_req++;
  endtask

  task automatic start_ray(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz);
    ray_req_t q;
    q.action = 0;
    q.org = '{ox, oy, oz};
    q.dir = '{dx, dy, dz};
    q.solid = 1'($urandom_range(1));
    q.kind = 8'($urandom);
    send_request(q);
  endtask

  task automatic answer(logic solid, logic [7:0] kind);
    ray_req_t q;
    q.action = 1;
    q.org = '{$urandom, $urandom, $urandom};
    q.dir = '{16'($urandom), 16'($urandom), 16'($urandom)};
    q.solid = solid;
    q.kind = kind;
    send_request(q);
  endtask

  // Limit writes only once everything is drained
  task automatic set_limit(logic [23:0] v);
    s_axis_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i <= 1;
    @(posedge clk_i);
    cfg_we_i <= 0;
    lim_q = v;
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768)) - 16'd16384;
    endcase
  endfunction

  function automatic logic [31:0] rand_org();
    if ($urandom_range(3) == 0) return $urandom;
    return {16'($urandom_range(0, 64)) - 16'd32, 16'($urandom)};
  endfunction

  task automatic test_directed();
    // answers with no ray in flight
    answer(1, 8'hFF);
    answer(0, 8'h00);
    // axis-aligned and zero direction components
    start_ray(32'h0000_8000, 0, 0, 16'h4000, 0, 0);
    answer(0, 0);
    answer(0, 0);
    answer(1, 8'h7F);
    start_ray(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'hC000);
    answer(0, 0);
    // start dropping a live ray
    start_ray(32'h7FFF_0000, 32'h8000_0000, 0, 16'h7FFF, 16'h8000, 16'h0001);
    answer(0, 0);
    answer(0, 0);
    start_ray(0, 0, 0, 0, 0, 0);
    answer(0, 0);
    answer(1, 8'h80);
    answer(0, 0);
    start_ray(32'h0001_0000, 32'hFFFF_0000, 0, 16'h2D41, 16'hD2BF, 0);
    answer(1, 8'h55);
  endtask

  task automatic test_limits();
    set_limit(24'd0);                  // start misses at once
    start_ray(0, 0, 0, 16'h4000, 0, 0);
    answer(0, 0);
    set_limit(24'hFF_FFFF);
    start_ray(32'h0000_FFFF, 0, 0, 16'h4000, 16'h0100, 16'hFF00);
    repeat (4) answer(0, 0);
    answer(1, 8'hAA);
    set_limit(24'h01_0000);
    start_ray(0, 0, 0, 16'h2000, 16'h2000, 16'h2000);
    repeat (5) answer(0, 0);
  endtask

  // Well-formed rays with random content plus some stray answers
  task automatic test_random_rays(int target, logic [23:0] lim);
    int len;
    set_limit(lim);
    while (n_req < target) begin
      if ($urandom_range(9) == 0) begin
        answer(1'($urandom_range(1)), 8'($urandom));
        continue;
      end
      start_ray(rand_org(), rand_org(), rand_org(), rand_dir(), rand_dir(), rand_dir());
      len = $urandom_range(0, 30);
      for (int k = 0; k < len && active_q; k++)
        answer($urandom_range(99) < 8, 8'($urandom));
    end
  endtask

  // Result side: random stall, long calm stretch handled by 'calm'
  always @(posedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= 37);

  always @(posedge clk_i) begin
    ray_res_t e;
    logic [87:0] d;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      d = m_axis_tdata;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, m_axis_tuser, d);
        errors++;
      end else begin
        e = pending_q.pop_front();
        case (e.kind)
          vrds_pkg::KIND_HIT: n_hit++;
          vrds_pkg::KIND_MISS: n_miss++;
          default: n_query++;
        endcase
        if (m_axis_tuser !== e.kind) begin
          $display("%0t: kind exp %0d got %0d", $time, e.kind, m_axis_tuser); errors++;
        end
        for (int i = 0; i < 3; i++) begin
          if (d[16*i +: 16] !== e.vox[i]) begin
            $display("%0t: voxel[%0d] exp %h got %h", $time, i, e.vox[i],
                     d[16*i +: 16]); errors++;
          end
          if (d[48 + 8*i +: 8] !== e.loc[i]) begin
            $display("%0t: local[%0d] exp %h got %h", $time, i, e.loc[i],
                     d[48 + 8*i +: 8]); errors++;
          end
          if (d[72 + 2*i +: 2] !== e.nrm[i]) begin
            $display("%0t: normal[%0d] exp %b got %b", $time, i, e.nrm[i],
                     d[72 + 2*i +: 2]); errors++;
          end
        end
        if (d[85:78] !== e.hit_kind) begin
          $display("%0t: hit_kind exp %h got %h", $time, e.hit_kind, d[85:78]); errors++;
        end
        if (d[87:86] !== 2'b00) begin
          $display("%0t: pad exp 0 got %b", $time, d[87:86]); errors++;
        end
      end
    end
  end

  // Watchdog: ends the run with an error once the quiet count passes its threshold
  always @(posedge clk_i)
    if (quiet > 5000) begin
      $display("tb: errors");
      $finish;
    end

  initial begin
    lim_q = vrds_pkg::MaxDistReset;
    pos_q = '{default: '0};
    cross_q = '{default: '0};
    unit_q = '{default: '0};
    neg_q = '{default: 0};
    trav_q = 0;
    axis_q = 0;
    active_q = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_random_rays(450, vrds_pkg::MaxDistReset);
    calm = 1;
    test_random_rays(650, 24'h02_8000);
    calm = 0;
    test_random_rays(900, 24'h00_4000);
    test_random_rays(1120, 24'h0C_0000);
    s_axis_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests: %0d queries, %0d hits, %0d misses checked",
             n_req, n_query, n_hit, n_miss);
    $display("Limits swept: zero, 0.25, 1.0, 2.5, 5.0, 12.0 and full scale");
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/vrds_pkg.sv
hdl/vrds_ctrl.sv
hdl/vrds_dp.sv
hdl/voxel_ray_dda_stepper.sv
test/tb.sv
